@@ hw/rtl/mandelbrot_escape_time_pixel_defines.svh @@
// assertion macros used by the checker file
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// general clocked assertion, off while reset is low
`define METP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a signal holds while its channel is stalled
`define METP_ASSERT_HOLD(label, vld, rdy, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

@@ hw/rtl/metp_pkg.sv @@
package metp_pkg;

    // fixed point format and dimension limit
    localparam int FRAC_BITS = 28;
    localparam int MAX_DIM   = 4096;

    // squared escape radius (4) in the doubled fraction format
    localparam int          RADIUS_SHIFT = 2 * FRAC_BITS + 2;
    localparam bit          RADIUS_FITS  = (RADIUS_SHIFT < 64);
    localparam logic [63:0] RADIUS_SQ    = RADIUS_FITS ? (64'd1 << RADIUS_SHIFT) : '1;

    // register file
    localparam int REG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_CENTER_RE      = 3'd0,
        REG_CENTER_IM      = 3'd1,
        REG_PIXEL_STEP     = 3'd2,
        REG_MAX_ITERATIONS = 3'd3,
        REG_IMAGE_WIDTH    = 3'd4,
        REG_IMAGE_HEIGHT   = 3'd5
    } reg_index_t;

    localparam logic [30:0] PIXEL_STEP_RST     = 31'd1342177;
    localparam logic [15:0] MAX_ITERATIONS_RST = 16'd255;
    localparam logic [12:0] IMAGE_WIDTH_RST    = 13'd640;
    localparam logic [12:0] IMAGE_HEIGHT_RST   = 13'd480;

    // number of items circulating in the iteration loop
    localparam int TOKENS = 3;
    localparam int TAG_W  = $clog2(TOKENS);

    typedef struct packed {
        logic [31:0] center_re;
        logic [31:0] center_im;
        logic [30:0] pixel_step;
        logic [15:0] max_iterations;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic [15:0] iteration_count;
        logic        escaped;
        logic        outside_at_start;
        logic [31:0] final_re;
        logic [31:0] final_im;
    } result_t;

    // clamp a signed value to the signed 32 bit range
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/metp_cfg.sv @@
module metp_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [metp_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output metp_pkg::cfg_t                    cfg
);

    metp_pkg::cfg_t       cfg_reg;
    metp_pkg::reg_index_t index;
    logic                 write_en;

    assign index    = metp_pkg::reg_index_t'(paddr[metp_pkg::REG_ADDR_W-1:2]);
    assign write_en = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_re      <= '0;
            cfg_reg.center_im      <= '0;
            cfg_reg.pixel_step     <= metp_pkg::PIXEL_STEP_RST;
            cfg_reg.max_iterations <= metp_pkg::MAX_ITERATIONS_RST;
            cfg_reg.image_width    <= metp_pkg::IMAGE_WIDTH_RST;
            cfg_reg.image_height   <= metp_pkg::IMAGE_HEIGHT_RST;
        end
        else if (write_en)
        begin
            unique case (index)
                metp_pkg::REG_CENTER_RE:      cfg_reg.center_re      <= pwdata;
                metp_pkg::REG_CENTER_IM:      cfg_reg.center_im      <= pwdata;
                metp_pkg::REG_PIXEL_STEP:     cfg_reg.pixel_step     <= pwdata[30:0];
                metp_pkg::REG_MAX_ITERATIONS: cfg_reg.max_iterations <= pwdata[15:0];
                metp_pkg::REG_IMAGE_WIDTH:    cfg_reg.image_width    <= pwdata[12:0];
                metp_pkg::REG_IMAGE_HEIGHT:   cfg_reg.image_height   <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            metp_pkg::REG_CENTER_RE:      prdata = cfg_reg.center_re;
            metp_pkg::REG_CENTER_IM:      prdata = cfg_reg.center_im;
            metp_pkg::REG_PIXEL_STEP:     prdata = {1'b0, cfg_reg.pixel_step};
            metp_pkg::REG_MAX_ITERATIONS: prdata = {16'd0, cfg_reg.max_iterations};
            metp_pkg::REG_IMAGE_WIDTH:    prdata = {19'd0, cfg_reg.image_width};
            metp_pkg::REG_IMAGE_HEIGHT:   prdata = {19'd0, cfg_reg.image_height};
            default:                      prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/metp_map.sv @@
module metp_map
(
    input  logic           clk,
    input  logic           rst_n,
    input  metp_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [11:0]    pixel_x,
    input  logic [11:0]    pixel_y,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    c_re,
    output logic [31:0]    c_im
);

    // stage 1: offsets from the image center
    logic               v1_reg;
    logic signed [13:0] dx_reg, dy_reg;
    // stage 2: scaled offsets
    logic               v2_reg;
    logic signed [45:0] px_reg, py_reg;
    // stage 3: mapped point
    logic               v3_reg;
    logic [31:0]        c_re_reg, c_im_reg;

    logic               rdy1, rdy2, rdy3;
    logic [12:0]        w_eff, h_eff;
    logic [11:0]        half_w, half_h;
    logic signed [13:0] dx_next, dy_next;
    logic signed [31:0] step_s;
    logic signed [45:0] px_next, py_next;
    logic signed [63:0] sum_re, sum_im;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        w_eff   = (32'(cfg.image_width) > metp_pkg::MAX_DIM) ? 13'(metp_pkg::MAX_DIM)
                                                              : cfg.image_width;
        h_eff   = (32'(cfg.image_height) > metp_pkg::MAX_DIM) ? 13'(metp_pkg::MAX_DIM)
                                                               : cfg.image_height;
        half_w  = w_eff[12:1];
        half_h  = h_eff[12:1];
        dx_next = $signed({2'b00, pixel_x}) - $signed({2'b00, half_w});
        dy_next = $signed({2'b00, half_h}) - $signed({2'b00, pixel_y});
        step_s  = $signed({1'b0, cfg.pixel_step});
        px_next = 46'(dx_reg) * 46'(step_s);
        py_next = 46'(dy_reg) * 46'(step_s);
        sum_re  = 64'(px_reg) + 64'($signed(cfg.center_re));
        sum_im  = 64'(py_reg) + 64'($signed(cfg.center_im));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (rdy2 && v1_reg)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (rdy3 && v2_reg)
        begin
            c_re_reg <= metp_pkg::sat32(sum_re);
            c_im_reg <= metp_pkg::sat32(sum_im);
        end
    end

    assign out_valid = v3_reg;
    assign c_re      = c_re_reg;
    assign c_im      = c_im_reg;

endmodule

@@ hw/rtl/metp_iter.sv @@
module metp_iter
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       max_iterations,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       in_c_re,
    input  logic [31:0]       in_c_im,
    output logic              out_valid,
    input  logic              out_ready,
    output metp_pkg::result_t result
);

    typedef logic [metp_pkg::TAG_W-1:0] tag_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        tag_t        tag;
        logic [15:0] count;
        logic        so;
        logic        esc;
        logic [31:0] re;
        logic [31:0] im;
        logic [31:0] c_re;
        logic [31:0] c_im;
    } token_t;

    // empty slot carrying its fixed tag
    function automatic token_t idle_token(input tag_t t);
        token_t tk;
        tk     = '0;
        tk.tag = t;
        return tk;
    endfunction

    // three register stages form a ring; each holds one item slot
    token_t             s0_reg, s1_reg, s2_reg;
    token_t             s0_next;
    logic signed [63:0] rr_reg, ii_reg, ri_reg;
    logic signed [63:0] diff_reg, ri2_reg;
    logic               inside_reg;
    tag_t               load_ptr_reg, ret_ptr_reg;
    logic               out_valid_reg;
    metp_pkg::result_t  result_reg;

    logic signed [63:0] rr_next, ii_next, ri_next;
    logic [63:0]        mag;
    logic               inside_next;
    logic signed [63:0] nre_wide, nim_wide;
    logic               retire, load, go_on;

    // stage 0 -> 1: squares and cross product
    always_comb
    begin
        rr_next = 64'($signed(s0_reg.re)) * 64'($signed(s0_reg.re));
        ii_next = 64'($signed(s0_reg.im)) * 64'($signed(s0_reg.im));
        ri_next = 64'($signed(s0_reg.re)) * 64'($signed(s0_reg.im));
    end

    // stage 1 -> 2: radius test and difference of squares
    always_comb
    begin
        mag         = 64'(rr_reg) + 64'(ii_reg);
        inside_next = !metp_pkg::RADIUS_FITS || (mag <= metp_pkg::RADIUS_SQ);
    end

    // stage 2 -> 0: next z, loop decision, load and retire
    always_comb
    begin
        nre_wide = (diff_reg >>> metp_pkg::FRAC_BITS) + 64'($signed(s2_reg.c_re));
        nim_wide = (ri2_reg >>> (metp_pkg::FRAC_BITS - 1)) + 64'($signed(s2_reg.c_im));
        retire   = s2_reg.busy && s2_reg.done && (s2_reg.tag == ret_ptr_reg)
                   && (!out_valid_reg || out_ready);
        in_ready = !s2_reg.busy && (s2_reg.tag == load_ptr_reg);
        load     = in_ready && in_valid;
        go_on    = (s2_reg.count < max_iterations) && inside_reg;
        s0_next  = s2_reg;
        if (load)
        begin
            s0_next.busy  = 1'b1;
            s0_next.done  = 1'b0;
            s0_next.count = '0;
            s0_next.so    = 1'b0;
            s0_next.esc   = 1'b0;
            s0_next.re    = in_c_re;
            s0_next.im    = in_c_im;
            s0_next.c_re  = in_c_re;
            s0_next.c_im  = in_c_im;
        end
        else if (retire)
        begin
            s0_next.busy = 1'b0;
            s0_next.done = 1'b0;
        end
        else if (s2_reg.busy && !s2_reg.done)
        begin
            if (s2_reg.count == '0)
                s0_next.so = !inside_reg;
            if (go_on)
            begin
                s0_next.re    = metp_pkg::sat32(nre_wide);
                s0_next.im    = metp_pkg::sat32(nim_wide);
                s0_next.count = s2_reg.count + 16'd1;
            end
            else
            begin
                s0_next.done = 1'b1;
                s0_next.esc  = !inside_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg        <= idle_token(tag_t'(2));
            s1_reg        <= idle_token(tag_t'(1));
            s2_reg        <= idle_token(tag_t'(0));
            load_ptr_reg  <= '0;
            ret_ptr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_reg <= s0_next;
            s1_reg <= s0_reg;
            s2_reg <= s1_reg;
            if (load)
                load_ptr_reg <= (load_ptr_reg == tag_t'(metp_pkg::TOKENS - 1))
                                ? '0 : load_ptr_reg + tag_t'(1);
            if (retire)
                ret_ptr_reg <= (ret_ptr_reg == tag_t'(metp_pkg::TOKENS - 1))
                               ? '0 : ret_ptr_reg + tag_t'(1);
            if (retire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rr_reg     <= rr_next;
        ii_reg     <= ii_next;
        ri_reg     <= ri_next;
        diff_reg   <= rr_reg - ii_reg;
        ri2_reg    <= ri_reg;
        inside_reg <= inside_next;
        if (retire)
        begin
            result_reg.iteration_count  <= s2_reg.count;
            result_reg.escaped          <= s2_reg.esc;
            result_reg.outside_at_start <= s2_reg.so;
            result_reg.final_re         <= s2_reg.re;
            result_reg.final_im         <= s2_reg.im;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

@@ hw/rtl/mandelbrot_escape_time_pixel.sv @@
// flow: coordinate mapping in three register stages, a wait until the free loop slot comes by,
//   then one pass of the 3-stage loop per iteration, then the output register;
//   a pixel also waits while an older one still iterates, results leave in input order
// sharing: up to 3 pixels share the loop, each item making one pass per iteration,
//   so the sustained pixel rate is set by the loop around the squaring multipliers
// reset: rst_n async active low clears all valid bits and restores register defaults
module mandelbrot_escape_time_pixel
(
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel input words
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,   // pixel_x[11:0], pixel_y[23:12]
    // result output words
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [79:0]                     m_axis_tdata,   // iteration_count[15:0],
                                                            // final_re[47:16], final_im[79:48]
    output logic [1:0]                      m_axis_tuser,   // escaped[0], outside_at_start[1]
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [metp_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    metp_pkg::cfg_t    cfg;
    metp_pkg::result_t result;
    logic              map_valid;
    logic              map_ready;
    logic [31:0]       c_re;
    logic [31:0]       c_im;

    // register file: view center, step, iteration limit, image size
    metp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pixel to complex plane, three stages: offset, scale, add center and saturate
    metp_map u_map
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .pixel_x   (s_axis_tdata[11:0]),
        .pixel_y   (s_axis_tdata[23:12]),
        .out_valid (map_valid),
        .out_ready (map_ready),
        .c_re      (c_re),
        .c_im      (c_im)
    );

    // escape-time loop: products, radius test, update; slots retire in load order
    metp_iter u_iter
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_iterations (cfg.max_iterations),
        .in_valid       (map_valid),
        .in_ready       (map_ready),
        .in_c_re        (c_re),
        .in_c_im        (c_im),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .result         (result)
    );

    // pack the result word, count in the low bits
    assign m_axis_tdata = {result.final_im, result.final_re, result.iteration_count};
    assign m_axis_tuser = {result.outside_at_start, result.escaped};

endmodule

@@ hw/rtl/metp_checker.sv @@
`include "mandelbrot_escape_time_pixel_defines.svh"

module metp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic [15:0] count;

    assign count = m_axis_tdata[15:0];

    `METP_ASSERT_HOLD(a_out_valid_hold, m_axis_tvalid, m_axis_tready, m_axis_tvalid, "result word dropped while stalled")
    `METP_ASSERT_HOLD(a_out_data_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "result word changed while stalled")
    `METP_ASSERT(a_outside_no_iter, (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tuser[0] && count == 16'd0), "start outside must escape with zero count")
    `METP_ASSERT(a_zero_count_inside, (m_axis_tvalid && count == 16'd0 && !m_axis_tuser[1]) |-> !m_axis_tuser[0], "zero count inside start cannot escape")

endmodule

bind mandelbrot_escape_time_pixel metp_checker u_metp_checker (.*);
